// File: rtl/core/hts_pkg.sv
package hts_pkg;

    localparam int WIN_DEPTH = 7;
    localparam int BUF_DEPTH = WIN_DEPTH + 1;
    localparam int POS_W     = $clog2(BUF_DEPTH);
    localparam int FILL_W    = $clog2(BUF_DEPTH + 1);
    localparam int OUT_DEPTH = 2;
    localparam int OCNT_W    = $clog2(OUT_DEPTH + 1);

    localparam int SCRIPT_LEN = 6;
    localparam int STYLE_LEN  = 5;
    localparam int OFF_OPEN   = 1;
    localparam int OFF_CLOSE  = 2;

    typedef logic [7:0]                 t_byte;
    typedef t_byte [BUF_DEPTH-1:0]      t_buf;
    typedef logic [POS_W-1:0]           t_pos;
    typedef logic [FILL_W-1:0]          t_fill;
    typedef logic [OCNT_W-1:0]          t_ocnt;

    localparam t_byte CH_SPACE  = 8'h20;
    localparam t_byte CH_TAB    = 8'h09;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_VT     = 8'h0B;
    localparam t_byte CH_FF     = 8'h0C;
    localparam t_byte CH_CR     = 8'h0D;
    localparam t_byte CH_LT     = 8'h3C;
    localparam t_byte CH_GT     = 8'h3E;
    localparam t_byte CH_SLASH  = 8'h2F;
    localparam t_byte CASE_BIT  = 8'h20;

    localparam t_byte KW_SCRIPT [SCRIPT_LEN] = '{8'h73, 8'h63, 8'h72, 8'h69, 8'h70, 8'h74};
    localparam t_byte KW_STYLE  [STYLE_LEN]  = '{8'h73, 8'h74, 8'h79, 8'h6C, 8'h65};

    typedef enum logic [1:0] {
        PH_RUN,
        PH_FLUSH,
        PH_FINISH
    } t_phase;

    typedef struct packed {
        t_pos skip;
        logic tag;
        logic script;
        logic style;
        logic last_space;
    } t_scan;

    typedef struct packed {
        logic  emit;
        t_byte data;
        t_scan scan;
    } t_decision;

    typedef struct packed {
        t_byte char_out;
        logic  char_valid;
        logic  end_of_text;
    } t_result;

endpackage

// File: rtl/core/hts_if.sv
interface hts_in_if;
    logic                 valid;
    logic                 ready;
    hts_pkg::t_byte       char_in;
    logic                 last_in;

    modport source (output valid, output char_in, output last_in, input ready);
    modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

interface hts_out_if;
    logic                 valid;
    logic                 ready;
    hts_pkg::t_byte       char_out;
    logic                 char_valid;
    logic                 end_of_text;

    modport source (output valid, output char_out, output char_valid, output end_of_text,
                    input ready);
    modport sink   (input valid, input char_out, input char_valid, input end_of_text,
                    output ready);
endinterface

// File: rtl/core/hts_decide.sv
module hts_decide (
    input  hts_pkg::t_buf      i_buf,
    input  hts_pkg::t_pos      i_avail,
    input  hts_pkg::t_scan     i_scan,
    output hts_pkg::t_decision o_dec
);

    function automatic logic is_ws(input hts_pkg::t_byte c);
        return c == hts_pkg::CH_SPACE || c == hts_pkg::CH_TAB || c == hts_pkg::CH_LF ||
               c == hts_pkg::CH_VT || c == hts_pkg::CH_FF || c == hts_pkg::CH_CR;
    endfunction

    function automatic logic word_script(input hts_pkg::t_buf b, input int base);
        logic hit;
        hit = 1'b1;
        for (int k = 0; k < hts_pkg::SCRIPT_LEN; k++) begin
            if ((b[hts_pkg::POS_W'(base + k)] | hts_pkg::CASE_BIT) != hts_pkg::KW_SCRIPT[k]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic word_style(input hts_pkg::t_buf b, input int base);
        logic hit;
        hit = 1'b1;
        for (int k = 0; k < hts_pkg::STYLE_LEN; k++) begin
            if ((b[hts_pkg::POS_W'(base + k)] | hts_pkg::CASE_BIT) != hts_pkg::KW_STYLE[k]) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    hts_pkg::t_byte c;
    logic           is_lt;
    logic           in_body;
    logic           tag_now;
    logic           close_script;
    logic           close_style;
    logic           open_script;
    logic           open_style;

    always_comb begin
        c       = i_buf[0];
        is_lt   = c == hts_pkg::CH_LT;
        in_body = i_scan.script || i_scan.style;
        tag_now = i_scan.tag || is_lt;

        close_script = in_body && is_lt && i_buf[1] == hts_pkg::CH_SLASH &&
                       i_avail >= hts_pkg::POS_W'(hts_pkg::OFF_CLOSE + hts_pkg::SCRIPT_LEN - 1) &&
                       word_script(i_buf, hts_pkg::OFF_CLOSE);
        close_style  = in_body && is_lt && i_buf[1] == hts_pkg::CH_SLASH &&
                       i_avail >= hts_pkg::POS_W'(hts_pkg::OFF_CLOSE + hts_pkg::STYLE_LEN - 1) &&
                       word_style(i_buf, hts_pkg::OFF_CLOSE);
        open_script  = i_avail >= hts_pkg::POS_W'(hts_pkg::OFF_OPEN + hts_pkg::SCRIPT_LEN - 1) &&
                       word_script(i_buf, hts_pkg::OFF_OPEN);
        open_style   = i_avail >= hts_pkg::POS_W'(hts_pkg::OFF_OPEN + hts_pkg::STYLE_LEN - 1) &&
                       word_style(i_buf, hts_pkg::OFF_OPEN);

        o_dec.emit = 1'b0;
        o_dec.data = '0;
        o_dec.scan = i_scan;

        if (i_scan.skip != '0) begin
            o_dec.scan.skip = i_scan.skip - 1'b1;
        end else if (close_script) begin
            o_dec.scan.script = 1'b0;
            o_dec.scan.skip   = hts_pkg::POS_W'(hts_pkg::SCRIPT_LEN + 1);
        end else if (close_style) begin
            o_dec.scan.style = 1'b0;
            o_dec.scan.skip  = hts_pkg::POS_W'(hts_pkg::STYLE_LEN + 1);
        end else begin
            o_dec.scan.tag = tag_now;
            if (tag_now && open_script) begin
                o_dec.scan.script = 1'b1;
                o_dec.scan.skip   = hts_pkg::POS_W'(hts_pkg::SCRIPT_LEN);
            end else if (tag_now && open_style) begin
                o_dec.scan.style = 1'b1;
                o_dec.scan.skip  = hts_pkg::POS_W'(hts_pkg::STYLE_LEN);
            end else if (!in_body && tag_now) begin
                if (c == hts_pkg::CH_GT) begin
                    o_dec.scan.tag = 1'b0;
                end
            end else if (!in_body) begin
                if (is_ws(c)) begin
                    if (!i_scan.last_space) begin
                        o_dec.emit            = 1'b1;
                        o_dec.data            = hts_pkg::CH_SPACE;
                        o_dec.scan.last_space = 1'b1;
                    end
                end else begin
                    o_dec.emit            = 1'b1;
                    o_dec.data            = c;
                    o_dec.scan.last_space = 1'b0;
                end
            end
        end
    end

endmodule

// File: rtl/core/html_tag_stripper.sv
// HTML text extractor. Raw document bytes enter on the i_in channel, one byte per beat,
// with last_in set on the final byte. Kept text leaves on the o_out channel, with each
// whitespace run in the kept text collapsed to one space.
// Seven bytes of lookahead are held, so the result for a byte is decided when the seventh
// following byte is accepted and then passes through the output queue to o_out. Input bytes
// are taken at one per cycle while the queue has room and no flush is under way; the
// per-byte keyword compare and flag update sit between the window register and a two-entry
// output queue. A beat with last_in starts a flush: the pending bytes (up to eight) are
// decided one per cycle while the queue has room and a closing beat follows; i_in stays
// not ready until the closing beat is queued. The last result carries end_of_text; if the
// flush kept no text, a single beat with char_valid low and end_of_text high is sent. The
// phase, fill, scan and hold state then return to their reset values for the next document.
// Synchronous reset clears the scan flags, the fill count and the output queue.
// When the receiver stalls, the output queue fills and i_in drops ready once it holds
// two beats; nothing is lost or repeated.
module html_tag_stripper (
    input logic         i_clk,
    input logic         i_rst_n,
    hts_in_if.sink      i_in,
    hts_out_if.source   o_out
);

    hts_pkg::t_phase    r_phase, n_phase;
    hts_pkg::t_buf      r_win, n_win;
    hts_pkg::t_fill     r_fill, n_fill;
    hts_pkg::t_scan     r_scan, n_scan;
    logic               r_hold_vld, n_hold_vld;
    hts_pkg::t_byte     r_hold_data, n_hold_data;
    hts_pkg::t_result   r_q [hts_pkg::OUT_DEPTH];
    hts_pkg::t_result   n_q [hts_pkg::OUT_DEPTH];
    hts_pkg::t_ocnt     r_q_cnt, n_q_cnt;

    hts_pkg::t_buf      dec_buf;
    hts_pkg::t_pos      dec_avail;
    hts_pkg::t_decision dec;
    logic               room;
    logic               accept;
    logic               pop;
    logic               push;
    hts_pkg::t_result   push_data;

    hts_decide u_decide (
        .i_buf   (dec_buf),
        .i_avail (dec_avail),
        .i_scan  (r_scan),
        .o_dec   (dec)
    );

    assign room        = r_q_cnt != hts_pkg::OCNT_W'(hts_pkg::OUT_DEPTH);
    assign i_in.ready  = r_phase == hts_pkg::PH_RUN && room;
    assign accept      = i_in.valid && i_in.ready;
    assign pop         = r_q_cnt != '0 && o_out.ready;

    assign o_out.valid       = r_q_cnt != '0;
    assign o_out.char_out    = r_q[0].char_out;
    assign o_out.char_valid  = r_q[0].char_valid;
    assign o_out.end_of_text = r_q[0].end_of_text;

    always_comb begin
        dec_buf = r_win;
        if (r_phase == hts_pkg::PH_RUN) begin
            dec_buf[hts_pkg::BUF_DEPTH-1] = i_in.char_in;
            dec_avail = hts_pkg::POS_W'(hts_pkg::WIN_DEPTH);
        end else begin
            dec_avail = hts_pkg::POS_W'(r_fill - 1'b1);
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_win       = r_win;
        n_fill      = r_fill;
        n_scan      = r_scan;
        n_hold_vld  = r_hold_vld;
        n_hold_data = r_hold_data;
        push        = 1'b0;
        push_data   = '0;

        unique case (r_phase)
            hts_pkg::PH_RUN: begin
                if (accept) begin
                    if (i_in.last_in || r_fill != hts_pkg::FILL_W'(hts_pkg::WIN_DEPTH)) begin
                        n_win[r_fill[hts_pkg::POS_W-1:0]] = i_in.char_in;
                        n_fill = r_fill + 1'b1;
                        if (i_in.last_in) begin
                            n_phase = hts_pkg::PH_FLUSH;
                        end
                    end else begin
                        for (int k = 0; k < hts_pkg::BUF_DEPTH - 1; k++) begin
                            n_win[k] = dec_buf[k+1];
                        end
                        n_scan    = dec.scan;
                        push      = dec.emit;
                        push_data = '{char_out: dec.data, char_valid: 1'b1, end_of_text: 1'b0};
                    end
                end
            end
            hts_pkg::PH_FLUSH: begin
                if (room) begin
                    for (int k = 0; k < hts_pkg::BUF_DEPTH - 1; k++) begin
                        n_win[k] = dec_buf[k+1];
                    end
                    n_scan = dec.scan;
                    n_fill = r_fill - 1'b1;
                    if (dec.emit) begin
                        push        = r_hold_vld;
                        push_data   = '{char_out: r_hold_data, char_valid: 1'b1,
                                        end_of_text: 1'b0};
                        n_hold_vld  = 1'b1;
                        n_hold_data = dec.data;
                    end
                    if (r_fill == hts_pkg::FILL_W'(1)) begin
                        n_phase = hts_pkg::PH_FINISH;
                    end
                end
            end
            hts_pkg::PH_FINISH: begin
                if (room) begin
                    push       = 1'b1;
                    push_data  = '{char_out: r_hold_vld ? r_hold_data : '0,
                                   char_valid: r_hold_vld, end_of_text: 1'b1};
                    n_hold_vld = 1'b0;
                    n_scan     = '0;
                    n_fill     = '0;
                    n_phase    = hts_pkg::PH_RUN;
                end
            end
            default: begin
                n_phase = hts_pkg::PH_RUN;
            end
        endcase
    end

    always_comb begin
        n_q     = r_q;
        n_q_cnt = r_q_cnt;
        if (pop) begin
            n_q[0]  = r_q[1];
            n_q_cnt = r_q_cnt - 1'b1;
        end
        if (push) begin
            n_q[n_q_cnt[0]] = push_data;
            n_q_cnt         = n_q_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= hts_pkg::PH_RUN;
            r_fill     <= '0;
            r_scan     <= '0;
            r_hold_vld <= 1'b0;
            r_q_cnt    <= '0;
        end else begin
            r_phase    <= n_phase;
            r_fill     <= n_fill;
            r_scan     <= n_scan;
            r_hold_vld <= n_hold_vld;
            r_q_cnt    <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win       <= n_win;
        r_hold_data <= n_hold_data;
        r_q         <= n_q;
    end

    a_last_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.last_in) |=> !i_in.ready)
        else $error("input ready straight after the final beat of a document");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hts_pkg::PH_FINISH && room) |=>
        (r_fill == '0 && r_scan == '0 && !r_hold_vld))
        else $error("scan state not cleared at the end of a document");

    a_no_skip_while_filling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hts_pkg::PH_RUN && r_fill != hts_pkg::FILL_W'(hts_pkg::WIN_DEPTH)) |->
        r_scan.skip == '0)
        else $error("skip count set before the window is full");

    a_empty_beat_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.char_valid) |-> o_out.end_of_text)
        else $error("beat without text that does not end the document");

endmodule

// File: tb/tb_html_tag_stripper.sv
`timescale 1ns / 1ps

module tb_html_tag_stripper;
    import hts_pkg::*;

    localparam string SCRIPT_WORD = "script";
    localparam string STYLE_WORD  = "style";
    localparam int    HOLD_CYCLES = 400;
    localparam int    DRAIN_LIMIT = 20000;
    localparam int    TAIL_CYCLES = 24;
    localparam int    RANDOM_BEATS = 150;

    typedef enum int {
        RX_OPEN,
        RX_HALF,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    hts_in_if  in_ch ();
    hts_out_if out_ch ();

    html_tag_stripper u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Predicted state of the stripper.
    t_byte       pend_bytes [WIN_DEPTH];
    int          pend_count  = 0;
    int          skip_left   = 0;
    bit          in_tag_f    = 1'b0;
    bit          in_script_f = 1'b0;
    bit          in_style_f  = 1'b0;
    bit          prev_blank  = 1'b0;

    t_byte       decided_q [$];
    t_result     kept_text_q [$];
    t_byte       doc_q [$];

    int          fault_count  = 0;
    int          beats_sent   = 0;
    int          docs_sent    = 0;
    int          results_seen = 0;
    int          burst_left   = 0;
    bit          hold_start   = 1'b0;
    int          hold_left    = 0;
    t_rx_mode    rx_mode      = RX_OPEN;
    int          rx_left      = 0;

    function automatic bit is_blank(t_byte c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT ||
               c == CH_FF || c == CH_CR;
    endfunction

    function automatic bit keyword_follows(t_buf b, int p, int avail, int off, string w);
        int len;
        len = w.len();
        if (off + len - 1 > avail)
            return 1'b0;
        for (int k = 0; k < len; k++) begin
            if ((b[p + off + k] | CASE_BIT) != t_byte'(w[k]))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic add_byte(input t_byte c);
        doc_q.insert(doc_q.size(), c);
    endtask

    task automatic keep_text_byte(input t_byte c);
        t_byte v;
        v = c;
        if (is_blank(v)) begin
            if (prev_blank)
                return;
            prev_blank = 1'b1;
            v = CH_SPACE;
        end else begin
            prev_blank = 1'b0;
        end
        decided_q.insert(decided_q.size(), v);
    endtask

    task automatic classify_byte(input t_buf b, input int p, input int avail);
        t_byte c;
        c = b[p];
        if (skip_left > 0) begin
            skip_left--;
            return;
        end
        if ((in_script_f || in_style_f) && c == CH_LT && avail >= 1 && b[p + 1] == CH_SLASH) begin
            if (keyword_follows(b, p, avail, OFF_CLOSE, SCRIPT_WORD)) begin
                in_script_f = 1'b0;
                skip_left   = OFF_CLOSE - 1 + SCRIPT_LEN;
                return;
            end
            if (keyword_follows(b, p, avail, OFF_CLOSE, STYLE_WORD)) begin
                in_style_f = 1'b0;
                skip_left  = OFF_CLOSE - 1 + STYLE_LEN;
                return;
            end
        end
        if (c == CH_LT)
            in_tag_f = 1'b1;
        if (in_tag_f) begin
            if (keyword_follows(b, p, avail, OFF_OPEN, SCRIPT_WORD)) begin
                in_script_f = 1'b1;
                skip_left   = SCRIPT_LEN;
                return;
            end
            if (keyword_follows(b, p, avail, OFF_OPEN, STYLE_WORD)) begin
                in_style_f = 1'b1;
                skip_left  = STYLE_LEN;
                return;
            end
        end
        if (in_script_f || in_style_f)
            return;
        if (in_tag_f) begin
            if (c == CH_GT)
                in_tag_f = 1'b0;
            return;
        end
        keep_text_byte(c);
    endtask

    task automatic predict_kept_text(input t_byte c, input logic is_last);
        t_buf    b;
        int      n;
        t_result r;
        b = '0;
        for (int i = 0; i < pend_count; i++)
            b[i] = pend_bytes[i];
        b[pend_count] = c;
        n = pend_count + 1;
        decided_q.delete();
        if (!is_last) begin
            if (n == BUF_DEPTH) begin
                classify_byte(b, 0, WIN_DEPTH);
                for (int i = 0; i < WIN_DEPTH; i++)
                    pend_bytes[i] = b[i + 1];
                pend_count = WIN_DEPTH;
            end else begin
                pend_bytes[pend_count] = c;
                pend_count = n;
            end
        end else begin
            for (int p = 0; p < n; p++)
                classify_byte(b, p, n - 1 - p);
            pend_count  = 0;
            skip_left   = 0;
            in_tag_f    = 1'b0;
            in_script_f = 1'b0;
            in_style_f  = 1'b0;
            prev_blank  = 1'b0;
        end
        for (int i = 0; i < decided_q.size(); i++) begin
            r.char_out    = decided_q[i];
            r.char_valid  = 1'b1;
            r.end_of_text = is_last && (i == decided_q.size() - 1);
            kept_text_q.insert(kept_text_q.size(), r);
        end
        if (is_last && decided_q.size() == 0) begin
            r.char_out    = '0;
            r.char_valid  = 1'b0;
            r.end_of_text = 1'b1;
            kept_text_q.insert(kept_text_q.size(), r);
        end
    endtask

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen++;
            if (kept_text_q.size() == 0) begin
                note_fault($sformatf("unexpected result char %02h valid %0b end %0b",
                    out_ch.char_out, out_ch.char_valid, out_ch.end_of_text));
            end else begin
                want = kept_text_q.pop_front();
                if (out_ch.char_out !== want.char_out || out_ch.char_valid !== want.char_valid ||
                    out_ch.end_of_text !== want.end_of_text)
                    note_fault($sformatf({"result %0d: expected char %02h valid %0b end %0b,",
                        " got char %02h valid %0b end %0b"},
                        results_seen, want.char_out, want.char_valid, want.end_of_text,
                        out_ch.char_out, out_ch.char_valid, out_ch.end_of_text));
            end
        end
    end

    // Receiver: stall pattern of its own, plus a long hold when asked.
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(8, 64);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:   out_ch.ready <= 1'b1;
                RX_HALF:   out_ch.ready <= ($urandom_range(0, 1) != 0);
                RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                default:   out_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic send_beat(input t_byte c, input logic is_last);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.char_in <= c;
        in_ch.last_in <= is_last;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        predict_kept_text(c, is_last);
        beats_sent++;
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_q.size(); i++)
            send_beat(doc_q[i], i == doc_q.size() - 1);
        docs_sent++;
    endtask

    task automatic add_raw(input string s);
        for (int k = 0; k < s.len(); k++)
            add_byte(t_byte'(s[k]));
    endtask

    function automatic t_byte any_case(t_byte c);
        return ($urandom_range(0, 1) != 0) ? (c & ~CASE_BIT) : c;
    endfunction

    task automatic add_word(input string w, input int len);
        for (int k = 0; k < len; k++)
            add_byte(any_case(t_byte'(w[k])));
    endtask

    function automatic t_byte blank_byte();
        t_byte r;
        case ($urandom_range(0, 5))
            0:       r = CH_SPACE;
            1:       r = CH_TAB;
            2:       r = CH_LF;
            3:       r = CH_VT;
            4:       r = CH_FF;
            default: r = CH_CR;
        endcase
        return r;
    endfunction

    function automatic t_byte text_byte();
        t_byte r;
        case ($urandom_range(0, 3))
            0:       r = t_byte'(8'h61 + $urandom_range(0, 25));
            1:       r = t_byte'(8'h41 + $urandom_range(0, 25));
            2:       r = t_byte'($urandom_range(8'h21, 8'h7E));
            default: r = blank_byte();
        endcase
        return r;
    endfunction

    task automatic build_doc();
        string kw;
        int    plen;
        doc_q.delete();
        repeat ($urandom_range(1, 5)) begin
            kw = ($urandom_range(0, 1) != 0) ? SCRIPT_WORD : STYLE_WORD;
            case ($urandom_range(0, 11))
                0, 1: begin
                    repeat ($urandom_range(1, 6)) add_byte(text_byte());
                end
                2: begin
                    add_byte(CH_LT);
                    repeat ($urandom_range(1, 3))
                        add_byte(t_byte'(8'h61 + $urandom_range(0, 25)));
                    if ($urandom_range(0, 2) == 0) begin
                        add_byte(CH_SPACE);
                        add_word(kw, kw.len());
                    end
                    add_byte(CH_GT);
                end
                3, 4, 5, 6: begin
                    add_byte(CH_LT);
                    add_word(kw, kw.len());
                    add_byte(CH_GT);
                    repeat ($urandom_range(0, 5))
                        add_byte(($urandom_range(0, 4) == 0) ? CH_LT : text_byte());
                    add_byte(CH_LT);
                    add_byte(CH_SLASH);
                    add_word(kw, kw.len());
                    if ($urandom_range(0, 3) != 0)
                        add_byte(CH_GT);
                end
                7: begin
                    repeat ($urandom_range(1, 4)) add_byte(t_byte'($urandom_range(0, 255)));
                end
                8: begin
                    add_byte(CH_LT);
                    if ($urandom_range(0, 1) != 0)
                        add_byte(CH_SLASH);
                    plen = $urandom_range(1, kw.len() - 1);
                    add_word(kw, plen);
                end
                9: begin
                    repeat ($urandom_range(1, 4)) add_byte(blank_byte());
                end
                10: begin
                    case ($urandom_range(0, 2))
                        0:       add_byte(CH_LT);
                        1:       add_byte(CH_GT);
                        default: add_byte(CH_SLASH);
                    endcase
                end
                default: begin
                    add_byte(CH_LT);
                    add_byte(CH_SLASH);
                    add_word(kw, kw.len());
                    add_byte(CH_GT);
                end
            endcase
        end
    endtask

    task automatic test_extremes_and_blanks();
        doc_q.delete();
        add_byte(8'h00);
        add_byte(CH_SPACE);
        add_byte(CH_TAB);
        add_byte(CH_LF);
        add_byte(CH_VT);
        add_byte(CH_FF);
        add_byte(CH_CR);
        add_byte(8'hFF);
        send_doc();
    endtask

    task automatic test_markup_only();
        doc_q.delete();
        add_raw("<i>");
        send_doc();
    endtask

    task automatic test_style_body();
        doc_q.delete();
        add_raw("<Style>a</style>b");
        send_doc();
    endtask

    task automatic test_keyword_at_end();
        doc_q.delete();
        add_raw("x<STYL");
        send_doc();
    endtask

    task automatic test_backpressure();
        doc_q.delete();
        repeat (40) add_byte(t_byte'(8'h61 + $urandom_range(0, 25)));
        hold_start = 1'b1;
        send_doc();
    endtask

    task automatic test_random_documents();
        int start;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            build_doc();
            send_doc();
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        while (kept_text_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        while (kept_text_q.size() != 0) begin
            void'(kept_text_q.pop_front());
            note_fault("expected result never arrived");
        end
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.char_in <= '0;
        in_ch.last_in <= 1'b0;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes_and_blanks();
        test_markup_only();
        test_style_body();
        test_keyword_at_end();
        test_backpressure();
        test_random_documents();
        drain_results();

        $display("Run covered %0d documents, %0d input beats and %0d output beats,",
            docs_sent, beats_sent, results_seen);
        $display("with tag, script and style bodies, whitespace runs and a long output hold.");
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches in total", fault_count);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results still expected", kept_text_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/hts_pkg.sv
rtl/core/hts_if.sv
rtl/core/hts_decide.sv
rtl/core/html_tag_stripper.sv
tb/tb_html_tag_stripper.sv
